// ----- rtl/lmst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmst_pkg: shared types and constants of the LED multiplex scan timebase
// Item kinds, back-end states, queue entry, divider request/response, widths.
// ----------------------------------------------------------------------------
package lmst_pkg;

  localparam int unsigned ClockHzW    = 27;
  localparam int unsigned CounterW    = 16;
  localparam int unsigned LedCountW   = 5;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 27;
  localparam int unsigned PinW        = 4;
  localparam int unsigned PosW        = 5;
  localparam int unsigned MicrosW     = 32;
  localparam int unsigned KhzW        = 18;

  localparam int unsigned InDataW     = 16;
  localparam int unsigned InUserW     = 2;
  localparam int unsigned OutDataW    = 48;

  localparam int unsigned DivNumW     = 73;
  localparam int unsigned DivDenW     = 27;
  localparam int unsigned DivQuoW     = 32;
  localparam int unsigned DivCntW     = 7;

  localparam logic [ClockHzW-1:0]  ClockHzReset    = 27'd14000000;
  localparam logic [CounterW-1:0]  CounterTopReset = 16'd65535;
  localparam logic [LedCountW-1:0] LedCountReset   = 5'd16;

  localparam logic [CounterW-1:0]  OffDelayTicks   = 16'd10;
  localparam logic [PosW-1:0]      PosNone         = 5'd31;
  localparam logic [14:0]          UsScale         = 15'd31250;
  localparam int unsigned          UsShift         = 9;
  localparam logic [13:0]          TickUsMul       = 14'd16000;

  // floor(hz / 1000) as (hz * KhzRecip) >> KhzShift, exact for any 27-bit hz
  localparam int unsigned          KhzProdW        = 55;
  localparam logic [27:0]          KhzRecip        = 28'd137438954;
  localparam int unsigned          KhzShift        = 37;

  localparam int unsigned UsNumW      = 30;
  localparam int unsigned OvfProdAW   = 49;
  localparam int unsigned OvfProdBW   = 64;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_HZ    = 2'd0,
    CFG_COUNTER_TOP = 2'd1,
    CFG_LED_COUNT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_LIGHT,
    ST_MUL_A,
    ST_MUL_B,
    ST_OVF_GO,
    ST_OVF_WAIT,
    ST_KHZ,
    ST_US_GO,
    ST_US_WAIT,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    op_e             op;
    logic            wr_ok;
    logic [3:0]      entry;
    logic [PinW-1:0] cathode;
    logic [PinW-1:0] anode;
  } q_item_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivCntW-1:0] nbits;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivQuoW-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/lmst_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmst_front: input acceptance and classification
// Decodes each input transaction into a queue entry and holds up to two
// entries for the back end.
// ----------------------------------------------------------------------------
module lmst_front #(
  parameter int unsigned MAX_LEDS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry[3:0], cathode_line[7:4], anode_line[11:8], zero[15:12]
  input  wire  [lmst_pkg::InDataW-1:0] s_axis_tdata,
  // kind[1:0]
  input  wire  [lmst_pkg::InUserW-1:0] s_axis_tuser,
  output logic                         q_valid_o,
  input  wire                          q_pop_i,
  output lmst_pkg::q_item_t            q_item_o
);
  import lmst_pkg::*;

  q_item_t    q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  q_item_t    item_in;
  logic       push;
  logic       pop;

  always_comb begin
    item_in.op      = op_e'(s_axis_tuser);
    item_in.entry   = s_axis_tdata[3:0];
    item_in.cathode = s_axis_tdata[7:4];
    item_in.anode   = s_axis_tdata[11:8];
    item_in.wr_ok   = ({28'd0, s_axis_tdata[3:0]} < 32'(MAX_LEDS));
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lmst_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmst_div: shared restoring divider
// One quotient bit per cycle over a left-aligned dividend; keeps the low
// quotient bits.
// ----------------------------------------------------------------------------
module lmst_div (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  lmst_pkg::div_req_t req_i,
  output lmst_pkg::div_rsp_t rsp_o
);
  import lmst_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivQuoW-1:0] quo_q, quo_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               ge;

  assign trial = {rem_q, num_q[DivNumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[DivNumW-2:0], 1'b0};
      rem_d = ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_d = {quo_q[DivQuoW-2:0], ge};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

// ----- rtl/lmst_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmst_back: timebase and scan execution
// Runs the tick counter, the LED scan sequencer, the overflow and time
// computations, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lmst_back #(
  parameter int unsigned MAX_LEDS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lmst_pkg::cfg_wr_t             cfg_i,
  input  wire                           q_valid_i,
  input  lmst_pkg::q_item_t             q_item_i,
  output logic                          q_pop_o,
  output lmst_pkg::div_req_t            div_req_o,
  input  lmst_pkg::div_rsp_t            div_rsp_i,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // anode_on[0], anode_pin[4:1], cathode_on[5], cathode_pin[9:6],
  // led_step[10], scan_done[11], micros[43:12], zero[47:44]
  output logic [lmst_pkg::OutDataW-1:0] m_axis_tdata
);
  import lmst_pkg::*;

  localparam int unsigned TabAw    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [6:0]  MaxLedsW = 7'(MAX_LEDS);

  back_state_e          state_q, state_d;
  logic [ClockHzW-1:0]  clock_hz_q, clock_hz_d;
  logic [CounterW-1:0]  top_q, top_d;
  logic [LedCountW-1:0] led_count_q, led_count_d;

  logic [CounterW-1:0]  tick_q, tick_d;
  logic [CounterW-1:0]  cmp_q, cmp_d;
  logic                 armed_q, armed_d;
  logic [MicrosW-1:0]   total_q, total_d;
  logic [MicrosW-1:0]   base_q, base_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 cath_on_q, cath_on_d;
  logic [PinW-1:0]      cath_pin_q, cath_pin_d;
  logic                 lit_on_q, lit_on_d;
  logic [PinW-1:0]      lit_pin_q, lit_pin_d;
  logic                 ovf_q, ovf_d;
  logic                 step_q, step_d;
  logic                 done_q, done_d;
  logic [MicrosW-1:0]   micros_q, micros_d;
  logic [KhzW-1:0]      khz_q, khz_d;
  logic [OvfProdAW-1:0] prod_a_q, prod_a_d;
  logic [OvfProdBW-1:0] prod_b_q, prod_b_d;
  logic                 ovalid_q, ovalid_d;
  logic [OutDataW-1:0]  odata_q, odata_d;

  logic [7:0]           tab_mem [MAX_LEDS];
  logic [7:0]           tab_rdata_q;
  logic                 tab_we;
  logic [TabAw-1:0]     tab_waddr;
  logic [TabAw-1:0]     tab_raddr;

  logic [CounterW-1:0]  tick_inc;
  logic                 tick_wrap;
  logic [PosW-1:0]      pos_inc;
  logic [6:0]           limit;
  logic                 in_scan;
  logic [CounterW:0]    period;
  logic [UsNumW-1:0]    us_num;
  logic [KhzProdW-1:0]  khz_prod;
  logic                 oload;

  assign tick_wrap = (tick_q >= top_q);
  assign tick_inc  = tick_wrap ? '0 : tick_q + CounterW'(1);
  assign pos_inc   = pos_q + PosW'(1);
  assign limit     = ({2'd0, led_count_q} < MaxLedsW) ? {2'd0, led_count_q} : MaxLedsW;
  assign in_scan   = ({2'd0, pos_inc} < limit);
  assign period    = {1'b0, top_q} + 17'd1;
  assign us_num    = UsNumW'(tick_q) * UsNumW'(TickUsMul);
  assign khz_prod  = KhzProdW'(clock_hz_q) * KhzProdW'(KhzRecip);
  assign tab_waddr = TabAw'(q_item_i.entry);
  assign tab_raddr = TabAw'(pos_inc);

  always_comb begin
    clock_hz_d  = clock_hz_q;
    top_d       = top_q;
    led_count_d = led_count_q;
    if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_CLOCK_HZ:    clock_hz_d  = cfg_i.data[ClockHzW-1:0];
        CFG_COUNTER_TOP: top_d       = cfg_i.data[CounterW-1:0];
        CFG_LED_COUNT:   led_count_d = cfg_i.data[LedCountW-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    cmp_d      = cmp_q;
    armed_d    = armed_q;
    total_d    = total_q;
    base_d     = base_q;
    pos_d      = pos_q;
    cath_on_d  = cath_on_q;
    cath_pin_d = cath_pin_q;
    lit_on_d   = lit_on_q;
    lit_pin_d  = lit_pin_q;
    ovf_d      = ovf_q;
    step_d     = step_q;
    done_d     = done_q;
    micros_d   = micros_q;
    khz_d      = khz_q;
    prod_a_d   = prod_a_q;
    prod_b_d   = prod_b_q;
    q_pop_o    = 1'b0;
    tab_we     = 1'b0;
    oload      = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.nbits = '0;
    div_req_o.den   = DivDenW'(1);

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          ovf_d    = 1'b0;
          step_d   = 1'b0;
          done_d   = 1'b0;
          micros_d = '0;
          case (q_item_i.op)
            OP_TICK: begin
              tick_d = tick_inc;
              ovf_d  = tick_wrap;
              if (tick_wrap) begin
                total_d = total_q + MicrosW'(1);
              end
              if (armed_q && (tick_inc == cmp_q)) begin
                step_d  = 1'b1;
                state_d = ST_STEP;
              end else if (tick_wrap) begin
                state_d = ST_MUL_A;
              end else begin
                state_d = ST_EMIT;
              end
            end
            OP_START: begin
              step_d  = 1'b1;
              state_d = ST_STEP;
            end
            OP_READ: begin
              state_d = ST_KHZ;
            end
            default: begin
              tab_we  = q_item_i.wr_ok;
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_STEP: begin
        lit_on_d  = 1'b0;
        lit_pin_d = '0;
        if (in_scan) begin
          pos_d   = pos_inc;
          state_d = ST_LIGHT;
        end else begin
          pos_d      = PosNone;
          cath_on_d  = 1'b0;
          cath_pin_d = '0;
          armed_d    = 1'b0;
          done_d     = 1'b1;
          state_d    = ovf_q ? ST_MUL_A : ST_EMIT;
        end
      end
      ST_LIGHT: begin
        cath_on_d  = 1'b1;
        cath_pin_d = tab_rdata_q[7:4];
        lit_on_d   = 1'b1;
        lit_pin_d  = tab_rdata_q[3:0];
        cmp_d      = tick_q + OffDelayTicks;
        armed_d    = 1'b1;
        state_d    = ovf_q ? ST_MUL_A : ST_EMIT;
      end
      ST_MUL_A: begin
        prod_a_d = OvfProdAW'(total_q) * OvfProdAW'(period);
        state_d  = ST_MUL_B;
      end
      ST_MUL_B: begin
        prod_b_d = OvfProdBW'(prod_a_q) * OvfProdBW'(UsScale);
        state_d  = ST_OVF_GO;
      end
      ST_OVF_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = {prod_b_q, {UsShift{1'b0}}};
        div_req_o.nbits = DivCntW'(DivNumW);
        div_req_o.den   = (clock_hz_q == '0) ? DivDenW'(1) : clock_hz_q;
        state_d         = ST_OVF_WAIT;
      end
      ST_OVF_WAIT: begin
        if (div_rsp_i.done) begin
          base_d  = div_rsp_i.quo;
          ovf_d   = 1'b0;
          state_d = ST_EMIT;
        end
      end
      ST_KHZ: begin
        khz_d   = khz_prod[KhzShift +: KhzW];
        state_d = ST_US_GO;
      end
      ST_US_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = {us_num, {(DivNumW-UsNumW){1'b0}}};
        div_req_o.nbits = DivCntW'(UsNumW);
        div_req_o.den   = (khz_q == '0) ? DivDenW'(1) : DivDenW'(khz_q);
        state_d         = ST_US_WAIT;
      end
      ST_US_WAIT: begin
        if (div_rsp_i.done) begin
          micros_d = base_q + div_rsp_i.quo;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          oload   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    if (oload) begin
      ovalid_d = 1'b1;
      odata_d  = {4'd0, micros_q, done_q, step_q, cath_pin_q, cath_on_q,
                  lit_pin_q, lit_on_q};
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clock_hz_q  <= ClockHzReset;
      top_q       <= CounterTopReset;
      led_count_q <= LedCountReset;
      tick_q      <= '0;
      cmp_q       <= '0;
      armed_q     <= 1'b0;
      total_q     <= '0;
      base_q      <= '0;
      pos_q       <= PosNone;
      cath_on_q   <= 1'b0;
      cath_pin_q  <= '0;
      lit_on_q    <= 1'b0;
      lit_pin_q   <= '0;
      ovf_q       <= 1'b0;
      step_q      <= 1'b0;
      done_q      <= 1'b0;
      micros_q    <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clock_hz_q  <= clock_hz_d;
      top_q       <= top_d;
      led_count_q <= led_count_d;
      tick_q      <= tick_d;
      cmp_q       <= cmp_d;
      armed_q     <= armed_d;
      total_q     <= total_d;
      base_q      <= base_d;
      pos_q       <= pos_d;
      cath_on_q   <= cath_on_d;
      cath_pin_q  <= cath_pin_d;
      lit_on_q    <= lit_on_d;
      lit_pin_q   <= lit_pin_d;
      ovf_q       <= ovf_d;
      step_q      <= step_d;
      done_q      <= done_d;
      micros_q    <= micros_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    khz_q    <= khz_d;
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    odata_q  <= odata_d;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= {q_item_i.cathode, q_item_i.anode};
    end
    tab_rdata_q <= tab_mem[tab_raddr];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule
`default_nettype wire

// ----- rtl/led_multiplex_scan_timebase_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// led_multiplex_scan_timebase_top: LED multiplex scan timebase
// Tick counter with overflow time base, compare-driven LED scan sequencer
// and microsecond time queries.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. A tick,
// start or table write passes through the emit state; a scan step adds the
// step state, and the light state when it lights an entry. A tick that wraps
// the counter adds two multiply stages, the divider start and a wait for the
// 73 quotient bits of the overflow time base. A time query first takes the
// kilohertz value from a reciprocal multiply, then the shared restoring
// divider produces the 30 quotient bits of the tick term at one bit per
// cycle. A result may wait for the output register to drain. A two-entry
// queue takes new transactions while the back end works or a result waits
// on the output register, until it is full. Table entries must be written
// before a scan reads them.
module led_multiplex_scan_timebase_top #(
  parameter int unsigned MAX_LEDS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [lmst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [lmst_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry[3:0], cathode_line[7:4], anode_line[11:8], zero[15:12]
  input  wire  [lmst_pkg::InDataW-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire  [lmst_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // anode_on[0], anode_pin[4:1], cathode_on[5], cathode_pin[9:6],
  // led_step[10], scan_done[11], micros[43:12], zero[47:44]
  output logic [lmst_pkg::OutDataW-1:0] m_axis_tdata
);
  import lmst_pkg::*;

  cfg_wr_t  cfg_wr;
  logic     q_valid;
  logic     q_pop;
  q_item_t  q_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  lmst_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_item_o      (q_item)
  );

  lmst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lmst_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_rsp.busy) |-> $past(div_req.start))
    else $error("divider busy without a start");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |=> !div_rsp.done)
    else $error("divider done held longer than one cycle");

endmodule
`default_nettype wire

// ----- test/tb_led_multiplex_scan_timebase_top.sv -----
// ----------------------------------------------------------------------------
// tb_led_multiplex_scan_timebase_top: self-checking bench for the LED scan timebase
// Streams ticks, scan starts, time queries and table writes through the block
// under bursty input and a stalling output. It predicts every result from its
// own copy of counter, scan and table state and compares each field. The run
// moves through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_led_multiplex_scan_timebase_top;
  import lmst_pkg::*;

  localparam int unsigned TblDepth   = 16;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainWait  = 100;
  localparam logic [79:0] UsNumScale = 80'd16000000;
  localparam logic [31:0] UsPerTick  = 32'd16000;
  localparam logic [26:0] HzPerKhz   = 27'd1000;

  typedef struct packed {
    op_e        kind;
    logic [3:0] entry;
    logic [3:0] cathode;
    logic [3:0] anode;
  } scan_cmd_t;

  typedef struct packed {
    logic        anode_on;
    logic [3:0]  anode_pin;
    logic        cathode_on;
    logic [3:0]  cathode_pin;
    logic        led_step;
    logic        scan_done;
    logic [31:0] micros;
  } scan_result_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_valid  = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data   = '0;
  logic [InUserW-1:0]  s_user   = '0;
  logic                m_valid;
  logic                m_ready  = 1'b0;
  logic [OutDataW-1:0] m_data;

  led_multiplex_scan_timebase_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [26:0] clk_hz_cfg;
  logic [15:0] top_cfg;
  logic [4:0]  leds_cfg;
  logic [15:0] ticks;
  logic [15:0] cmp_at;
  logic        cmp_on;
  logic [31:0] ovf_cnt;
  logic [31:0] base_us;
  logic [4:0]  scan_pos;
  logic [4:0]  lit_cath;
  logic [4:0]  lit_anode;
  logic [7:0]  led_tbl [TblDepth];

  scan_cmd_t    cmds_pending[$];
  scan_result_t results_due[$];
  scan_cmd_t    cur_cmd;
  scan_cmd_t    next_cmd;
  scan_result_t due_r;
  scan_result_t seen_r;

  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  logic [7:0]  stall_pat   = 8'h01;
  int unsigned quiet_cnt   = 0;
  int unsigned result_cnt  = 0;
  int unsigned fail_count  = 0;

  function automatic void recompute_base();
    logic [79:0] num;
    logic [79:0] den;
    ovf_cnt = ovf_cnt + 32'd1;
    den = (clk_hz_cfg == '0) ? 80'd1 : 80'(clk_hz_cfg);
    num = 80'(ovf_cnt) * (80'(top_cfg) + 80'd1) * UsNumScale;
    base_us = 32'(num / den);
  endfunction

  function automatic logic scan_advance();
    logic [4:0] span;
    logic [7:0] ent;
    span = (leds_cfg < 5'(TblDepth)) ? leds_cfg : 5'(TblDepth);
    lit_anode = PosNone;
    scan_pos = scan_pos + 5'd1;
    if (scan_pos >= span) begin
      scan_pos = PosNone;
      lit_cath = PosNone;
      cmp_on = 1'b0;
      return 1'b1;
    end
    ent = led_tbl[scan_pos[3:0]];
    lit_cath = {1'b0, ent[7:4]};
    cmp_at = ticks + OffDelayTicks;
    cmp_on = 1'b1;
    lit_anode = {1'b0, ent[3:0]};
    return 1'b0;
  endfunction

  function automatic scan_result_t scan_and_time(scan_cmd_t c);
    scan_result_t r;
    logic [26:0] khz;
    r = '0;
    case (c.kind)
      OP_TICK: begin
        if (ticks >= top_cfg) begin
          ticks = '0;
          recompute_base();
        end else begin
          ticks = ticks + 16'd1;
        end
        if (cmp_on && ticks == cmp_at) begin
          r.led_step = 1'b1;
          r.scan_done = scan_advance();
        end
      end
      OP_START: begin
        r.led_step = 1'b1;
        r.scan_done = scan_advance();
      end
      OP_READ: begin
        khz = clk_hz_cfg / HzPerKhz;
        if (khz == '0) khz = 27'd1;
        r.micros = base_us + (32'(ticks) * UsPerTick) / 32'(khz);
      end
      OP_WRITE: begin
        led_tbl[c.entry] = {c.cathode, c.anode};
      end
      default: ;
    endcase
    r.anode_on    = (lit_anode != PosNone);
    r.anode_pin   = (lit_anode != PosNone) ? lit_anode[3:0] : 4'd0;
    r.cathode_on  = (lit_cath != PosNone);
    r.cathode_pin = (lit_cath != PosNone) ? lit_cath[3:0] : 4'd0;
    return r;
  endfunction

  function automatic scan_cmd_t make_cmd(op_e k);
    scan_cmd_t c;
    c.kind    = k;
    c.entry   = 4'($urandom_range(0, 15));
    c.cathode = 4'($urandom_range(0, 15));
    c.anode   = 4'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic op_e scan_run_kind();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 82) return OP_TICK;
    if (pick < 92) return OP_READ;
    if (pick < 97) return OP_WRITE;
    return OP_START;
  endfunction

  // mostly a start followed by a run of mostly ticks, the rest random noise
  task automatic fill_phase(int unsigned n);
    int unsigned made;
    int unsigned run;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 75) begin
        cmds_pending.push_back(make_cmd(OP_START));
        made++;
        run = $urandom_range(4, 48);
        repeat (run) begin
          cmds_pending.push_back(make_cmd(scan_run_kind()));
          made++;
        end
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) begin
          cmds_pending.push_back(make_cmd(op_e'($urandom_range(0, 3))));
          made++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (cmds_pending.size() != 0 || s_valid || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CLOCK_HZ:    clk_hz_cfg = val;
      CFG_COUNTER_TOP: top_cfg = val[15:0];
      CFG_LED_COUNT:   leds_cfg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [26:0] hz, logic [15:0] top, logic [4:0] leds);
    wait_idle();
    repeat (4) @(posedge clk_i);
    write_reg(CFG_CLOCK_HZ, CfgDataW'(hz));
    write_reg(CFG_COUNTER_TOP, CfgDataW'(top));
    write_reg(CFG_LED_COUNT, CfgDataW'(leds));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (fail_count < 10)
        $display("result %0d: %s mismatch, expected %0h, got %0h",
                 result_cnt, field, want, got);
      fail_count++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid    <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_valid && s_ready)
        results_due.push_back(scan_and_time(cur_cmd));
      if (!s_valid || s_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_valid  <= 1'b0;
        end else if (cmds_pending.size() != 0) begin
          next_cmd = cmds_pending.pop_front();
          cur_cmd <= next_cmd;
          s_data  <= {4'd0, next_cmd.anode, next_cmd.cathode, next_cmd.entry};
          s_user  <= next_cmd.kind;
          s_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // output stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(16, 160);
        stall_mode = $urandom_range(0, 2);
        stall_pat  = (stall_mode == 2) ? 8'h01 << $urandom_range(0, 7)
                                       : 8'($urandom_range(1, 255));
      end else begin
        stall_left = stall_left - 1;
        stall_pat  = {stall_pat[6:0], stall_pat[7]};
      end
      m_ready <= (stall_mode == 0) || stall_pat[0];
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (results_due.size() == 0) begin
        if (fail_count < 10)
          $display("result %0d: unexpected transaction, data %0h", result_cnt, m_data);
        fail_count++;
      end else begin
        due_r = results_due.pop_front();
        seen_r.anode_on    = m_data[0];
        seen_r.anode_pin   = m_data[4:1];
        seen_r.cathode_on  = m_data[5];
        seen_r.cathode_pin = m_data[9:6];
        seen_r.led_step    = m_data[10];
        seen_r.scan_done   = m_data[11];
        seen_r.micros      = m_data[43:12];
        flag_field("anode_on", 32'(due_r.anode_on), 32'(seen_r.anode_on));
        flag_field("anode_pin", 32'(due_r.anode_pin), 32'(seen_r.anode_pin));
        flag_field("cathode_on", 32'(due_r.cathode_on), 32'(seen_r.cathode_on));
        flag_field("cathode_pin", 32'(due_r.cathode_pin), 32'(seen_r.cathode_pin));
        flag_field("led_step", 32'(due_r.led_step), 32'(seen_r.led_step));
        flag_field("scan_done", 32'(due_r.scan_done), 32'(seen_r.scan_done));
        flag_field("micros", due_r.micros, seen_r.micros);
      end
      result_cnt++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    scan_cmd_t c;
    clk_hz_cfg = ClockHzReset;
    top_cfg    = CounterTopReset;
    leds_cfg   = LedCountReset;
    ticks      = '0;
    cmp_at     = '0;
    cmp_on     = 1'b0;
    ovf_cnt    = '0;
    base_us    = '0;
    scan_pos   = PosNone;
    lit_cath   = PosNone;
    lit_anode  = PosNone;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the whole table first, pairs of entries share a cathode
    for (int i = 0; i < TblDepth; i++) begin
      c = make_cmd(OP_WRITE);
      c.entry   = 4'(i);
      c.cathode = 4'(15 - (i / 2) * 2);
      c.anode   = 4'(i);
      cmds_pending.push_back(c);
    end
    cmds_pending.push_back(make_cmd(OP_READ));
    cmds_pending.push_back(make_cmd(OP_START));
    cmds_pending.push_back(make_cmd(OP_START));
    cmds_pending.push_back(make_cmd(OP_TICK));
    cmds_pending.push_back(make_cmd(OP_READ));
    cmds_pending.push_back(make_cmd(OP_START));
    fill_phase(170);

    configure(27'd100000000, 16'd1, 5'd1);
    fill_phase(185);
    configure(27'd1000, 16'd300, 5'd16);
    fill_phase(185);
    configure(27'd0, 16'd0, 5'd0);
    fill_phase(185);
    configure(27'd999, 16'd40, 5'd31);
    fill_phase(185);
    configure(27'($urandom_range(1000, 100000000)), 16'd65535, 5'($urandom_range(1, 16)));
    fill_phase(185);
    configure(27'h7FFFFFF, 16'd12, 5'd5);
    fill_phase(185);

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- led_multiplex_scan_timebase_top.f -----
rtl/lmst_pkg.sv
rtl/lmst_front.sv
rtl/lmst_div.sv
rtl/lmst_back.sv
rtl/led_multiplex_scan_timebase_top.sv
test/tb_led_multiplex_scan_timebase_top.sv
